/* sv/bba_pkg.sv */
// Shared constants and codes for the bitmap block allocator.
package bba_pkg;

    // Build-time defaults
    localparam int NUM_BLOCKS_DEF        = 4096;
    localparam int FIRST_ALLOC_BLOCK_DEF = 3;

    // Free map word width
    localparam int MAP_WORD_W = 32;

    // Field widths
    localparam int CFG_W    = 13;
    localparam int OP_W     = 2;
    localparam int BLK_W    = 12;
    localparam int STATUS_W = 2;

    // Largest limit the block count register can express
    localparam int LIMIT_MAX = (1 << CFG_W) - 1;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

endpackage

/* sv/bba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bitmap_block_allocator_unit.sv */
// Top level of the first-fit bitmap block allocator.
//
//  channel   direction  handshake                 contents
//  s_*       in         s_tvalid / s_tready       request word
//  m_*       out        m_tvalid / m_tready       response word
//  cfg_*     in         cfg_wr_en                 total block count
//
// Free and in-range query read the map word, pass through S_FREE or S_QUERY
// and load the response from S_POST; an ignored free, an out-of-range query,
// an undefined op or an allocate with the limit at or below the first
// allocatable block go straight to S_POST. Allocate reads the free map one
// word per cycle through the RAM read port, up to the first word with a free
// block in range or up to the last word. One request is in work at a time.
// Reset clears the per-word valid bits at once, so the map reads as all used
// without a clearing pass. A stalled response holds the sequencer until taken.
module bitmap_block_allocator_unit #(
    parameter int NUM_BLOCKS        = bba_pkg::NUM_BLOCKS_DEF,
    parameter int FIRST_ALLOC_BLOCK = bba_pkg::FIRST_ALLOC_BLOCK_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // cfg_wr_data: total_blocks
    input  logic                         cfg_wr_en,
    input  logic [bba_pkg::CFG_W-1:0]    cfg_wr_data,
    // s_tdata: op[1:0], block_num[13:2], zero pad
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bba_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: status[1:0], grant_blk[13:2], is_free[14], zero pad
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bba_pkg::M_TDATA_W-1:0] m_tdata
);

    import bba_pkg::*;

    localparam int CAP       = (NUM_BLOCKS > LIMIT_MAX) ? LIMIT_MAX : NUM_BLOCKS;
    localparam int MAP_WORDS = (CAP + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [AW-1:0] FIRST_WORD = AW'(FIRST_ALLOC_BLOCK / MAP_WORD_W);
    localparam logic [4:0]    FIRST_BIT  = 5'(FIRST_ALLOC_BLOCK % MAP_WORD_W);
    localparam logic [MAP_WORD_W-1:0] LO_MASK = {MAP_WORD_W{1'b1}} << FIRST_BIT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_QUERY,
        S_POST
    } state_t;

    // Index of the single set bit of a one-hot word
    function automatic logic [4:0] onehot_index(input logic [MAP_WORD_W-1:0] oh);
        logic [4:0] idx;
        idx = '0;
        for (int j = 0; j < MAP_WORD_W; j++)
        begin
            if (oh[j])
            begin
                idx = idx | 5'(j);
            end
        end
        return idx;
    endfunction

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      total_reg, total_next;
    logic [MAP_WORDS-1:0]  valid_reg, valid_next;
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic [AW:0]           rd_word_reg, rd_word_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_word_reg, pend_word_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [BLK_W-1:0]      res_block_reg, res_block_next;
    logic                  res_free_reg, res_free_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [BLK_W-1:0]      out_block_reg, out_block_next;
    logic                  out_free_reg, out_free_next;

    // RAM port signals
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [MAP_WORD_W-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [MAP_WORD_W-1:0] ram_q;

    // Decoded request and limit terms
    logic [OP_W-1:0]       in_op;
    logic [CFG_W-1:0]      in_blk;
    logic [AW-1:0]         in_word;
    logic [AW-1:0]         blk_word;
    logic [CFG_W-1:0]      limit;
    logic [CFG_W-1:0]      lim_m1;
    logic [AW-1:0]         last_word;
    logic [MAP_WORD_W-1:0] hi_mask;
    logic [MAP_WORD_W-1:0] map_word;
    logic [MAP_WORD_W-1:0] cand;
    logic [MAP_WORD_W-1:0] cand_oh;
    logic [4:0]            cand_idx;
    logic [CFG_W-1:0]      granted;
    logic                  issue;

    bba_ram #(
        .WIDTH (MAP_WORD_W),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Request fields and limit
    assign in_op     = s_tdata[OP_W-1:0];
    assign in_blk    = {1'b0, s_tdata[OP_W+BLK_W-1:OP_W]};
    assign in_word   = AW'(in_blk >> 5);
    assign blk_word  = AW'(blk_reg >> 5);
    assign limit     = (total_reg > CFG_W'(CAP)) ? CFG_W'(CAP) : total_reg;
    assign lim_m1    = limit - CFG_W'(1);
    assign last_word = AW'(lim_m1 >> 5);
    assign hi_mask   = {MAP_WORD_W{1'b1}} >> (5'd31 - lim_m1[4:0]);

    // Word read back from the map; a never-written word reads as all used
    assign map_word = rd_vld_reg ? ram_q : '0;

    // Lowest free candidate in the scanned word
    always_comb
    begin
        cand = map_word;
        if (pend_word_reg == FIRST_WORD)
        begin
            cand = cand & LO_MASK;
        end
        if (pend_word_reg == last_word)
        begin
            cand = cand & hi_mask;
        end
    end

    assign cand_oh  = cand & (~cand + MAP_WORD_W'(1));
    assign cand_idx = onehot_index(cand_oh);
    assign granted  = (CFG_W'(pend_word_reg) << 5) | CFG_W'(cand_idx);
    assign issue    = rd_word_reg <= {1'b0, last_word};

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        total_next      = cfg_wr_en ? cfg_wr_data : total_reg;
        valid_next      = valid_reg;
        blk_next        = blk_reg;
        rd_word_next    = rd_word_reg;
        pend_next       = pend_reg;
        pend_word_next  = pend_word_reg;
        rd_vld_next     = rd_vld_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_free_next   = res_free_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        out_free_next   = out_free_reg;
        ram_we          = 1'b0;
        ram_waddr       = blk_word;
        ram_wdata       = map_word;
        ram_re          = 1'b0;
        ram_raddr       = in_word;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    blk_next        = in_blk[BLK_W-1:0];
                    res_status_next = ST_DONE;
                    res_block_next  = '0;
                    res_free_next   = 1'b0;
                    state_next      = S_POST;
                    unique case (in_op)
                        OP_ALLOC:
                        begin
                            if (limit <= CFG_W'(FIRST_ALLOC_BLOCK))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                rd_word_next = {1'b0, FIRST_WORD};
                                pend_next    = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            if (in_blk == '0 || in_blk >= limit)
                            begin
                                res_status_next = ST_IGNORED;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                rd_vld_next = valid_reg[in_word];
                                state_next  = S_FREE;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (in_blk < limit)
                            begin
                                ram_re      = 1'b1;
                                rd_vld_next = valid_reg[in_word];
                                state_next  = S_QUERY;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_DONE;
                        end
                    endcase
                end
            end

            // One word read per cycle, checked in the following cycle
            S_SCAN:
            begin
                ram_raddr      = rd_word_reg[AW-1:0];
                ram_re         = issue;
                rd_word_next   = rd_word_reg + (AW+1)'(1);
                pend_next      = issue;
                pend_word_next = rd_word_reg[AW-1:0];
                if (issue)
                begin
                    rd_vld_next = valid_reg[rd_word_reg[AW-1:0]];
                end
                if (pend_reg)
                begin
                    if (cand != '0)
                    begin
                        ram_we                    = 1'b1;
                        ram_waddr                 = pend_word_reg;
                        ram_wdata                 = map_word & ~cand_oh;
                        valid_next[pend_word_reg] = 1'b1;
                        res_status_next           = ST_DONE;
                        res_block_next            = granted[BLK_W-1:0];
                        state_next                = S_POST;
                    end
                    else if (pend_word_reg == last_word)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_POST;
                    end
                end
            end

            // Set the freed bit in its word
            S_FREE:
            begin
                ram_we               = 1'b1;
                ram_waddr            = blk_word;
                ram_wdata            = map_word | (MAP_WORD_W'(1) << blk_reg[4:0]);
                valid_next[blk_word] = 1'b1;
                state_next           = S_POST;
            end

            S_QUERY:
            begin
                res_free_next = map_word[blk_reg[4:0]];
                state_next    = S_POST;
            end

            // Hand the result to the output register once it is free
            S_POST:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_block_next  = res_block_reg;
                    out_free_next   = res_free_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            valid_reg      <= '0;
            pend_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            blk_reg        <= '0;
            rd_word_reg    <= '0;
            pend_word_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            res_status_reg <= ST_DONE;
            res_block_reg  <= '0;
            res_free_reg   <= 1'b0;
            out_status_reg <= ST_DONE;
            out_block_reg  <= '0;
            out_free_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            valid_reg      <= valid_next;
            pend_reg       <= pend_next;
            m_tvalid_reg   <= m_tvalid_next;
            blk_reg        <= blk_next;
            rd_word_reg    <= rd_word_next;
            pend_word_reg  <= pend_word_next;
            rd_vld_reg     <= rd_vld_next;
            res_status_reg <= res_status_next;
            res_block_reg  <= res_block_next;
            res_free_reg   <= res_free_next;
            out_status_reg <= out_status_next;
            out_block_reg  <= out_block_next;
            out_free_reg   <= out_free_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_free_reg, out_block_reg, out_status_reg};

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the first-fit bitmap block allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int NBLK       = NUM_BLOCKS_DEF;
    localparam int FIRST_BLK  = FIRST_ALLOC_BLOCK_DEF;
    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
    localparam int GAP_MAX    = 14;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 160;
    localparam int NUM_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int PRINT_MAX  = 100;
    localparam int DIR_N      = 25;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    grant_blk;
        logic                is_free;
    } resp_t;

    typedef struct packed {
        logic               cfg_en;
        logic [CFG_W-1:0]   cfg_val;
        logic [OP_W-1:0]    op;
        logic [BLK_W-1:0]   blk;
        logic               typed;
        resp_t              want;
    } dir_row_t;

    localparam resp_t R_DONE    = '{ST_DONE, 12'd0, 1'b0};
    localparam resp_t R_FULL    = '{ST_FULL, 12'd0, 1'b0};
    localparam resp_t R_IGNORED = '{ST_IGNORED, 12'd0, 1'b0};

    // Directed rows: an optional count write, then one request word.
    // Rows with typed clear are checked against the shadow map.
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{1'b0, 13'd0,    OP_ALLOC, 12'd0,    1'b1, R_FULL},    // count 0 after reset
        '{1'b0, 13'd0,    OP_QUERY, 12'd0,    1'b1, R_DONE},
        '{1'b0, 13'd0,    OP_FREE,  12'd5,    1'b1, R_IGNORED},
        '{1'b1, 13'd8191, OP_FREE,  12'd0,    1'b1, R_IGNORED}, // block zero never freed
        '{1'b0, 13'd0,    OP_FREE,  12'd4095, 1'b1, R_DONE},    // count capped to capacity
        '{1'b0, 13'd0,    OP_QUERY, 12'd4095, 1'b0, R_DONE},
        '{1'b0, 13'd0,    OP_ALLOC, 12'd4095, 1'b0, R_DONE},    // scan to last word
        '{1'b0, 13'd0,    OP_ALLOC, 12'd0,    1'b1, R_FULL},
        '{1'b0, 13'd0,    OP_FREE,  12'd1,    1'b1, R_DONE},
        '{1'b0, 13'd0,    OP_FREE,  12'd2,    1'b1, R_DONE},
        '{1'b0, 13'd0,    OP_ALLOC, 12'd0,    1'b1, R_FULL},    // below first alloc block
        '{1'b0, 13'd0,    OP_QUERY, 12'd1,    1'b0, R_DONE},
        '{1'b0, 13'd0,    OP_UNDEF, 12'd4095, 1'b1, R_DONE},    // undefined op
        '{1'b0, 13'd0,    OP_FREE,  12'd3,    1'b0, R_DONE},
        '{1'b0, 13'd0,    OP_ALLOC, 12'd0,    1'b0, R_DONE},
        '{1'b1, 13'd4096, OP_FREE,  12'd4095, 1'b0, R_DONE},
        '{1'b1, 13'd4097, OP_FREE,  12'd2048, 1'b0, R_DONE},
        '{1'b1, 13'd100,  OP_FREE,  12'd100,  1'b1, R_IGNORED}, // free at the limit
        '{1'b0, 13'd0,    OP_FREE,  12'd99,   1'b0, R_DONE},
        '{1'b0, 13'd0,    OP_QUERY, 12'd2048, 1'b1, R_DONE},    // free bit but out of range
        '{1'b0, 13'd0,    OP_ALLOC, 12'd0,    1'b0, R_DONE},
        '{1'b1, 13'd1,    OP_ALLOC, 12'd0,    1'b1, R_FULL},
        '{1'b1, 13'd4096, OP_ALLOC, 12'd0,    1'b0, R_DONE},
        '{1'b0, 13'd0,    OP_ALLOC, 12'd0,    1'b0, R_DONE},
        '{1'b0, 13'd0,    OP_QUERY, 12'd0,    1'b0, R_DONE}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the free map and block count
    logic [NBLK-1:0]  shadow_free = '0;
    logic [CFG_W-1:0] shadow_total = '0;
    int               granted_blocks[$];
    resp_t            expected_resp[$];

    int mismatch_count = 0;
    int idle_cycles = 0;
    int rx_stall = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    bitmap_block_allocator_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int usable_limit();
        return (int'(shadow_total) > NBLK) ? NBLK : int'(shadow_total);
    endfunction

    // Apply one request to the shadow map and return the response word
    function automatic resp_t serve_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
        resp_t r;
        int    lim;
        int    b;
        bit    hit;
        r   = R_DONE;
        lim = usable_limit();
        hit = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                r.status = ST_FULL;
                for (b = FIRST_BLK; b < lim && !hit; b++)
                begin
                    if (shadow_free[b])
                    begin
                        shadow_free[b] = 1'b0;
                        r.grant_blk    = BLK_W'(b);
                        r.status       = ST_DONE;
                        hit            = 1'b1;
                    end
                end
            end
            OP_FREE:
            begin
                if (blk == '0 || int'(blk) >= lim)
                    r.status = ST_IGNORED;
                else
                    shadow_free[blk] = 1'b1;
            end
            OP_QUERY:
                r.is_free = (int'(blk) < lim) && shadow_free[blk];
            default:
                ;
        endcase
        return r;
    endfunction

    // Block number for free and query: mostly in range or recently granted
    function automatic logic [BLK_W-1:0] pick_block();
        int sel;
        int lim;
        lim = usable_limit();
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return BLK_W'($urandom_range(0, NBLK - 1));
        if (sel == 2)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return BLK_W'(lim - 1);
                2: return BLK_W'(lim);
                default: return '1;
            endcase
        end
        if (sel < 6 && granted_blocks.size() > 0)
            return BLK_W'(granted_blocks[$urandom_range(0, granted_blocks.size() - 1)]);
        if (lim > 1)
            return BLK_W'($urandom_range(1, lim - 1));
        return BLK_W'($urandom_range(0, NBLK - 1));
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX)
            $display("%0t ns mismatch: %s", $time, what);
    endtask

    // Drive one request word and record its expected response
    task automatic send_request(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
                                input logic typed, input resp_t want);
        int    gap;
        resp_t pred;
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - BLK_W - OP_W){1'b0}}, blk, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pred = serve_request(op, blk);
        if (op == OP_ALLOC && pred.status == ST_DONE)
        begin
            granted_blocks.push_back(int'(pred.grant_blk));
            if (granted_blocks.size() > 64)
                void'(granted_blocks.pop_front());
        end
        expected_resp.push_back(typed ? want : pred);
    endtask

    // Stop sending and wait for every outstanding response
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_resp.size() != 0) @(posedge clk);
    endtask

    task automatic write_total(input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_total = val;
    endtask

    // Response sink with random stalls per word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                rx_stall = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            else if (rx_stall > 0)
                rx_stall = rx_stall - 1;
            m_tready <= (rx_stall == 0);
        end
    end

    // Response checker
    always @(posedge clk)
    begin : resp_check
        resp_t want;
        resp_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = m_tdata[1:0];
            got.grant_blk = m_tdata[13:2];
            got.is_free   = m_tdata[14];
            if (expected_resp.size() == 0)
                report_mismatch("response word with nothing expected");
            else
            begin
                want = expected_resp.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got.status, want.status));
                if (got.grant_blk !== want.grant_blk)
                    report_mismatch($sformatf("granted block %0d, want %0d",
                                              got.grant_blk, want.grant_blk));
                if (got.is_free !== want.is_free)
                    report_mismatch($sformatf("is_free %0b, want %0b",
                                              got.is_free, want.is_free));
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int               ph;
        int               i;
        int               sel;
        logic [OP_W-1:0]  op;
        logic [BLK_W-1:0] blk;
        int               totals [NUM_PHASES];
        totals = '{8191, 4096, 35, 4, 0, 64, 4097, 33, 4096, 4096};
        totals[8] = $urandom_range(5, 4095);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (i = 0; i < DIR_N; i++)
        begin
            if (DIR_ROWS[i].cfg_en)
            begin
                drain();
                write_total(DIR_ROWS[i].cfg_val);
            end
            send_request(DIR_ROWS[i].op, DIR_ROWS[i].blk, DIR_ROWS[i].typed,
                         DIR_ROWS[i].want);
        end

        // Random phases, one block count each
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            write_total(CFG_W'(totals[ph]));
            tx_burst = ($urandom_range(0, 2) == 0);
            rx_burst = ($urandom_range(0, 2) == 0);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 35)
                begin
                    op  = OP_ALLOC;
                    blk = BLK_W'($urandom_range(0, NBLK - 1));
                end
                else
                begin
                    op  = (sel < 65) ? OP_FREE : (sel < 93) ? OP_QUERY : OP_UNDEF;
                    blk = pick_block();
                end
                // occasional hold-off until the sink has caught up
                if ($urandom_range(0, 39) == 0)
                    drain();
                send_request(op, blk, 1'b0, R_DONE);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* bitmap_block_allocator_unit.f */
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bitmap_block_allocator_unit.sv
bench/testbench.sv
